// ===== hw/rtl/lkvt_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvt_pkg
// Shared types and constants of the linear key-value table: operation and
// status codes, field widths and packed stream widths.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Stream payloads, padded to whole bytes.
  localparam int unsigned IN_BITS   = OP_W + KEY_W + VALUE_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = STATUS_W + VALUE_W + COUNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/lkvt_ram.sv =====
// ----------------------------------------------------------------------------
// lkvt_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No reset on contents.
// ----------------------------------------------------------------------------
module lkvt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/linear_key_value_table.sv =====
// ----------------------------------------------------------------------------
// linear_key_value_table
// Small key-value table with linear search, kept packed in insertion order.
// ----------------------------------------------------------------------------
// Each input item carries an opcode (clear, insert/update, lookup, delete),
// a 64-bit key and a 64-bit value, and yields exactly one result item with
// a status, the value found on a lookup hit and the pair count after the
// operation. Keys and values sit in two synchronous RAMs of ENTRIES words,
// read one entry per cycle. Clear empties the table and goes straight to
// S_FIN without a scan. Insert, lookup and delete scan from entry 0 upward
// and stop at the first hit or after the last live entry. A delete hit at h
// then moves every later pair down one place, one pair per cycle through
// the RAM read port. The single read port walking the stores sets how long
// an item takes. One item is worked on at a time; the next is taken as
// soon as the result is parked in the output register, even while that
// result waits for m_tready. RAM contents need no clearing pass: only
// entries below the pair count are ever read.
// ----------------------------------------------------------------------------
module linear_key_value_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input items.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] opcode, [65:2] key, [129:66] value, [135:130] zero
  input  logic [lkvt_pkg::IN_DATA_W-1:0]  s_tdata,
  // Result items.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [1:0] status, [65:2] found_value, [70:66] entry_count, [71] zero
  output logic [lkvt_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t                             state;
  lkvt_pkg::op_t                      op_q;
  logic [lkvt_pkg::KEY_W-1:0]         key_q;
  logic [lkvt_pkg::VALUE_W-1:0]       val_q;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      ptr;
  logic                               rd_vld;
  logic [CW-1:0]                      rd_idx;
  lkvt_pkg::status_t                  res_status;
  logic [lkvt_pkg::VALUE_W-1:0]       res_value;

  logic                               s_acc;
  logic                               rd_issue;
  logic                               hit;
  logic                               last;
  logic                               miss;
  logic [CW+4:0]                      count_ext;

  logic                               kw_en;
  logic [IW-1:0]                      kw_addr;
  logic [lkvt_pkg::KEY_W-1:0]         kw_data;
  logic                               vw_en;
  logic [IW-1:0]                      vw_addr;
  logic [lkvt_pkg::VALUE_W-1:0]       vw_data;
  logic [lkvt_pkg::KEY_W-1:0]         key_rd;
  logic [lkvt_pkg::VALUE_W-1:0]       val_rd;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  // Issue one RAM read per cycle while walking live entries.
  assign rd_issue = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr < count);
  assign hit      = (state == S_SCAN) && rd_vld && (key_rd == key_q);
  assign last     = rd_vld && (rd_idx == (count - CW'(1)));
  // Miss: last live entry compared without a match, or nothing stored.
  assign miss     = (state == S_SCAN) && !hit && ((rd_vld && last) || (count == '0));

  lkvt_ram #(
    .WIDTH (lkvt_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (kw_en),
    .wr_addr (kw_addr),
    .wr_data (kw_data),
    .rd_en   (rd_issue),
    .rd_addr (ptr[IW-1:0]),
    .rd_data (key_rd)
  );

  lkvt_ram #(
    .WIDTH (lkvt_pkg::VALUE_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (vw_en),
    .wr_addr (vw_addr),
    .wr_data (vw_data),
    .rd_en   (rd_issue),
    .rd_addr (ptr[IW-1:0]),
    .rd_data (val_rd)
  );

  // Write-port steering: update in place on an insert hit, append on an insert
  // miss while not full, or move a pair down one slot while shifting after a delete.
  always_comb begin
    kw_en   = 1'b0;
    kw_addr = rd_idx[IW-1:0];
    kw_data = key_rd;
    vw_en   = 1'b0;
    vw_addr = rd_idx[IW-1:0];
    vw_data = val_rd;
    unique case (state)
      S_SCAN: begin
        if (hit && (op_q == lkvt_pkg::OP_INSERT)) begin
          vw_en   = 1'b1;
          vw_data = val_q;
        end else if (miss && (op_q == lkvt_pkg::OP_INSERT) && (count < FULL_COUNT)) begin
          kw_en   = 1'b1;
          kw_addr = count[IW-1:0];
          kw_data = key_q;
          vw_en   = 1'b1;
          vw_addr = count[IW-1:0];
          vw_data = val_q;
        end
      end
      S_SHIFT: begin
        if (rd_vld) begin
          kw_en   = 1'b1;
          kw_addr = rd_idx[IW-1:0] - IW'(1);
          vw_en   = 1'b1;
          vw_addr = rd_idx[IW-1:0] - IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {5'd0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ptr      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a stale read when a scan ends on a hit.
      rd_vld <= rd_issue && !hit;
      rd_idx <= ptr;
      // Restart the walk on a new item, jump past a deleted pair, else advance.
      if (s_acc) begin
        ptr <= '0;
      end else if (hit && (op_q == lkvt_pkg::OP_DELETE)) begin
        ptr <= rd_idx + CW'(1);
      end else if (rd_issue) begin
        ptr <= ptr + CW'(1);
      end
      if (m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            op_q       <= lkvt_pkg::op_t'(s_tdata[1:0]);
            key_q      <= s_tdata[65:2];
            val_q      <= s_tdata[129:66];
            res_status <= lkvt_pkg::ST_OK;
            res_value  <= '0;
            if (lkvt_pkg::op_t'(s_tdata[1:0]) == lkvt_pkg::OP_CLEAR) begin
              count <= '0;
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            state <= S_FIN;
            unique case (op_q)
              lkvt_pkg::OP_LOOKUP: begin
                res_value <= val_rd;
              end
              lkvt_pkg::OP_DELETE: begin
                if ((rd_idx + CW'(1)) < count) begin
                  state <= S_SHIFT;
                end else begin
                  count <= count - CW'(1);
                end
              end
              default: begin
              end
            endcase
          end else if (miss) begin
            state <= S_FIN;
            if (op_q == lkvt_pkg::OP_INSERT) begin
              if (count < FULL_COUNT) begin
                count <= count + CW'(1);
              end else begin
                res_status <= lkvt_pkg::ST_FULL;
              end
            end else begin
              res_status <= lkvt_pkg::ST_NOT_FOUND;
            end
          end
        end
        S_SHIFT: begin
          if (last) begin
            count <= count - CW'(1);
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // Park the result once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, count_ext[4:0], res_value, res_status};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("pair count above table size");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_vld)
    else $error("read data pending while idle");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    (s_acc && (s_tdata[1:0] == lkvt_pkg::OP_CLEAR)) |=> (count == '0))
    else $error("clear did not empty the table");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (kw_en || vw_en) |-> ((state == S_SCAN) || (state == S_SHIFT)))
    else $error("RAM write outside scan or shift");

endmodule
